>>> rtl/core/tsl_pkg.sv
// ----------------------------------------------------------------------------
// tsl_pkg
// Types, op codes and constant tables shared by the timestamped sample logger.
// ----------------------------------------------------------------------------
package tsl_pkg;

	localparam int SecPerMin    = 60;
	localparam int HoursPerDay  = 24;

	// op codes
	localparam logic [2:0] OP_TICK  = 3'd0;
	localparam logic [2:0] OP_SET   = 3'd1;
	localparam logic [2:0] OP_STORE = 3'd2;
	localparam logic [2:0] OP_READ  = 3'd3;
	localparam logic [2:0] OP_POLL  = 3'd4;

	// configuration register indexes
	localparam logic REG_TPS      = 1'b0;
	localparam logic REG_INTERVAL = 1'b1;

	localparam logic [15:0] TPS_RESET      = 16'd200;
	localparam logic [5:0]  INTERVAL_RESET = 6'd15;

	typedef struct packed {
		logic [2:0]  op;
		logic [7:0]  set_hours;
		logic [7:0]  set_minutes;
		logic [7:0]  set_seconds;
		logic        clear_log;
		logic [7:0]  temperature_in;
		logic [7:0]  humidity_in;
		logic [15:0] light_in;
		logic        reading_ok_in;
		logic [7:0]  read_index;
	} cmd_t;

	typedef struct packed {
		logic        valid_res;
		logic        due_flag;
		logic [4:0]  out_hours;
		logic [5:0]  out_minutes;
		logic [5:0]  out_seconds;
		logic [7:0]  temperature_out;
		logic [7:0]  humidity_out;
		logic [15:0] light_out;
		logic        reading_ok_out;
		logic [7:0]  entry_count;
	} res_t;

	// one log entry, 50 bits
	typedef struct packed {
		logic [4:0]  hours;
		logic [5:0]  minutes;
		logic [5:0]  seconds;
		logic [7:0]  temperature;
		logic [7:0]  humidity;
		logic [15:0] light;
		logic        ok;
	} log_entry_t;

	typedef logic [255:0][5:0] mod60_tab_t;
	typedef logic [255:0][4:0] mod24_tab_t;
	typedef logic [63:0][63:0] div_tab_t;

	// wrapping counter walks the residues
	function automatic mod60_tab_t build_mod60_tab();
		mod60_tab_t tab;
		int         r;
		r = 0;
		for (int i = 0; i < 256; i++) begin
			tab[i] = 6'(r);
			r = (r == SecPerMin - 1) ? 0 : r + 1;
		end
		return tab;
	endfunction

	function automatic mod24_tab_t build_mod24_tab();
		mod24_tab_t tab;
		int         r;
		r = 0;
		for (int i = 0; i < 256; i++) begin
			tab[i] = 5'(r);
			r = (r == HoursPerDay - 1) ? 0 : r + 1;
		end
		return tab;
	endfunction

	// bit [m][d] set when d divides m, m nonzero, d nonzero
	function automatic div_tab_t build_div_tab();
		div_tab_t tab;
		tab = '0;
		for (int d = 1; d < 64; d++) begin
			for (int m = d; m < 64; m += d) begin
				tab[m][d] = 1'b1;
			end
		end
		return tab;
	endfunction

	localparam mod60_tab_t MOD60_TAB = build_mod60_tab();
	localparam mod24_tab_t MOD24_TAB = build_mod24_tab();
	localparam div_tab_t   DIV_TAB   = build_div_tab();

endpackage

>>> rtl/core/timestamped_sample_logger_top.sv
// ----------------------------------------------------------------------------
// timestamped_sample_logger_top
// Time-of-day clock with a sample-due flag and a ring log of sensor readings.
// ----------------------------------------------------------------------------
// output: an item's result shows on result with done in the cycle after it
//   is accepted, set by the registered read of the log ram
// throughput: one item per cycle, busy stays low; the ram has separate write
//   and read ports and a read sees a store accepted the cycle before
// reset: arst_n clears time, prescaler, flag, pointer and count at once and
//   loads the register defaults; the log ram is not cleared
module timestamped_sample_logger_top #(
	parameter int LOG_DEPTH = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  tsl_pkg::cmd_t cmd,
	output logic          done,
	output tsl_pkg::res_t result,
	input  logic          cfg_we,
	input  logic          cfg_index,
	input  logic [15:0]   cfg_wdata
);

	import tsl_pkg::*;

	localparam int PTR_W = $clog2(LOG_DEPTH);
	localparam int CNT_W = $clog2(LOG_DEPTH + 1);

	// configuration
	logic [15:0] tps_q;
	logic [5:0]  interval_q;

	// clock state
	logic [15:0] tick_q;
	logic [4:0]  hours_q;
	logic [5:0]  minutes_q;
	logic [5:0]  seconds_q;
	logic        due_q;

	// log bookkeeping
	logic [PTR_W-1:0] wp_q;
	logic [CNT_W-1:0] count_q;

	// result side
	logic done_q;
	logic valid_q;
	logic from_entry_q;

	logic accept;
	assign accept = start && !busy;

	// busy never rises, no item is ever held off
	assign busy = 1'b0;

	// ------------------------------------------------------------------
	// tick path: prescaler, then seconds, minutes, hours
	// ------------------------------------------------------------------
	logic [16:0] tick_next;
	logic        sec_step;
	logic        min_step;
	logic [5:0]  minute_next;
	logic        hour_step;
	logic        due_hit;

	assign tick_next   = {1'b0, tick_q} + 17'd1;
	assign sec_step    = !(tick_next < {1'b0, tps_q});
	assign min_step    = sec_step && (seconds_q == 6'(SecPerMin - 1));
	// minute before the wrap, 1 to 60
	assign minute_next = minutes_q + 6'd1;
	assign hour_step   = min_step && (minute_next == 6'(SecPerMin));
	// interval of zero never matches, the table has no bit set for a divisor of zero
	assign due_hit     = min_step && DIV_TAB[minute_next][interval_q];

	// ------------------------------------------------------------------
	// read address: logical index to ring slot
	// ------------------------------------------------------------------
	logic [8:0]       idx_ext;
	logic [8:0]       cnt_ext;
	logic [8:0]       slot_sum;
	logic [8:0]       slot_wrap;
	logic [PTR_W-1:0] rd_slot;
	logic             rd_hit;
	logic             log_full;

	assign idx_ext   = {1'b0, cmd.read_index};
	assign cnt_ext   = 9'(count_q);
	assign log_full  = (cnt_ext == 9'(LOG_DEPTH));
	assign rd_hit    = idx_ext < cnt_ext;
	assign slot_sum  = 9'(wp_q) + idx_ext;
	// for an index that hits, the sum stays below twice the depth, one subtract is enough
	assign slot_wrap = (slot_sum >= 9'(LOG_DEPTH)) ? (slot_sum - 9'(LOG_DEPTH)) : slot_sum;
	assign rd_slot   = log_full ? slot_wrap[PTR_W-1:0] : idx_ext[PTR_W-1:0];

	// ------------------------------------------------------------------
	// log ram
	// ------------------------------------------------------------------
	log_entry_t wr_entry;
	log_entry_t rd_entry;
	logic       log_we;

	assign log_we = accept && (cmd.op == OP_STORE);

	always_comb begin
		wr_entry.hours       = hours_q;
		wr_entry.minutes     = minutes_q;
		wr_entry.seconds     = seconds_q;
		wr_entry.temperature = cmd.temperature_in;
		wr_entry.humidity    = cmd.humidity_in;
		wr_entry.light       = cmd.light_in;
		wr_entry.ok          = cmd.reading_ok_in;
	end

	tsl_ram #(
		.WIDTH($bits(log_entry_t)),
		.DEPTH(LOG_DEPTH)
	) u_log_ram (
		.clk  (clk),
		.we   (log_we),
		.waddr(wp_q),
		.wdata(wr_entry),
		.raddr(rd_slot),
		.rdata(rd_entry)
	);

	// ------------------------------------------------------------------
	// configuration writes
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tps_q      <= TPS_RESET;
			interval_q <= INTERVAL_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TPS:      tps_q      <= cfg_wdata;
				REG_INTERVAL: interval_q <= cfg_wdata[5:0];
				default:      tps_q      <= tps_q;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// item execution, all state updates land at the accept edge
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q       <= '0;
			hours_q      <= '0;
			minutes_q    <= '0;
			seconds_q    <= '0;
			due_q        <= 1'b0;
			wp_q         <= '0;
			count_q      <= '0;
			done_q       <= 1'b0;
			valid_q      <= 1'b0;
			from_entry_q <= 1'b0;
		end else begin
			done_q       <= accept;
			valid_q      <= 1'b0;
			from_entry_q <= 1'b0;
			if (accept) begin
				case (cmd.op)
					OP_TICK: begin
						if (!sec_step) begin
							tick_q <= tick_next[15:0];
						end else begin
							tick_q <= '0;
							if (!min_step) begin
								seconds_q <= seconds_q + 6'd1;
							end else begin
								seconds_q <= '0;
								if (due_hit) begin
									due_q <= 1'b1;
								end
								if (!hour_step) begin
									minutes_q <= minute_next;
								end else begin
									minutes_q <= '0;
									hours_q   <= (hours_q == 5'(HoursPerDay - 1)) ?
										5'd0 : hours_q + 5'd1;
								end
							end
						end
					end
					OP_SET: begin
						hours_q   <= MOD24_TAB[cmd.set_hours];
						minutes_q <= MOD60_TAB[cmd.set_minutes];
						seconds_q <= MOD60_TAB[cmd.set_seconds];
						tick_q    <= '0;
						// flag survives a set, log only on request
						if (cmd.clear_log) begin
							count_q <= '0;
							wp_q    <= '0;
						end
					end
					OP_STORE: begin
						wp_q <= (wp_q == PTR_W'(LOG_DEPTH - 1)) ? '0 : wp_q + PTR_W'(1);
						if (!log_full) begin
							count_q <= count_q + CNT_W'(1);
						end
					end
					OP_READ: begin
						valid_q      <= rd_hit;
						from_entry_q <= rd_hit;
					end
					OP_POLL: begin
						valid_q <= due_q;
						due_q   <= 1'b0;
					end
					default: begin
						// unused codes leave everything alone
						tick_q <= tick_q;
					end
				endcase
			end
		end
	end

	// ------------------------------------------------------------------
	// result: state registers already hold the post-item values
	// ------------------------------------------------------------------
	assign done = done_q;

	always_comb begin
		result.valid_res   = valid_q;
		result.due_flag    = due_q;
		result.entry_count = 8'(count_q);
		if (from_entry_q) begin
			result.out_hours       = rd_entry.hours;
			result.out_minutes     = rd_entry.minutes;
			result.out_seconds     = rd_entry.seconds;
			result.temperature_out = rd_entry.temperature;
			result.humidity_out    = rd_entry.humidity;
			result.light_out       = rd_entry.light;
			result.reading_ok_out  = rd_entry.ok;
		end else begin
			result.out_hours       = hours_q;
			result.out_minutes     = minutes_q;
			result.out_seconds     = seconds_q;
			result.temperature_out = '0;
			result.humidity_out    = '0;
			result.light_out       = '0;
			result.reading_ok_out  = 1'b0;
		end
	end

endmodule

>>> rtl/core/tsl_ram.sv
// ----------------------------------------------------------------------------
// tsl_ram
// Generic simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module tsl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/core/tsl_checker.sv
// ----------------------------------------------------------------------------
// tsl_checker
// Port-level checks for the timestamped sample logger, bound to the top level.
// ----------------------------------------------------------------------------
module tsl_checker #(
	parameter int LOG_DEPTH = 32
) (
	input logic          clk,
	input logic          arst_n,
	input logic          start,
	input logic          busy,
	input tsl_pkg::cmd_t cmd,
	input logic          done,
	input tsl_pkg::res_t result
);

	import tsl_pkg::*;

	// every accepted item gives exactly one result in the next cycle
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> done)
		else $error("accepted item gave no result");

	a_no_stray_result: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy))
		else $error("result without an accepted item");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> result.entry_count <= 8'(LOG_DEPTH))
		else $error("entry count above log depth");

	// invalid results carry no reading
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !result.valid_res |-> result.temperature_out == 8'd0 &&
			result.humidity_out == 8'd0 && result.light_out == 16'd0 &&
			!result.reading_ok_out)
		else $error("reading data on an invalid result");

	// a successful poll leaves the flag cleared
	a_poll_clears: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.valid_res && $past(cmd.op) == OP_POLL |-> !result.due_flag)
		else $error("poll did not clear the due flag");

endmodule

bind timestamped_sample_logger_top tsl_checker #(.LOG_DEPTH(LOG_DEPTH)) u_tsl_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.start (start),
	.busy  (busy),
	.cmd   (cmd),
	.done  (done),
	.result(result)
);
